FILE: hdl/tbee_pkg.sv
// Package for the text batch escape encoder.
// Holds the byte constants, the queue sizing and the command record that
// the front, the queue and the back all share. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbee_pkg;

  localparam int unsigned BATCH_CAPACITY_DEFAULT = 1024;
  localparam int unsigned HEADROOM               = 15;

  localparam logic [7:0] ESC_CHAR = 8'h23;
  localparam logic [7:0] FONT_TAG = 8'h66;
  localparam logic [7:0] XOFF_TAG = 8'h78;
  localparam logic [7:0] YOFF_TAG = 8'h79;
  localparam logic [7:0] FULL_BYTE = 8'h00;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic        full;
    logic        font_chg;
    logic        dx_nz;
    logic        dy_nz;
    logic        esc_lit;
    logic [7:0]  font;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  ch;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/tbee_front.sv
// Front end of the text batch escape encoder: accepts glyph transfers,
// tracks the batch byte count and last font, and issues one command each.
// Depends on tbee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbee_front #(
  parameter int unsigned BATCH_CAPACITY = tbee_pkg::BATCH_CAPACITY_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [tbee_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [0:0]                     s_tuser,
  output logic                                push,
  output tbee_pkg::cmd_t                      push_cmd,
  input  wire logic                           push_ready
);

  localparam int unsigned CNT_W = $clog2(BATCH_CAPACITY + 1);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       prev_font;
  logic             prev_font_valid;

  logic             start;
  logic [7:0]       font;
  logic [15:0]      dx;
  logic [15:0]      dy;
  logic [7:0]       ch;
  logic [CNT_W-1:0] cnt_eff;
  logic             valid_eff;
  logic [CNT_W:0]   with_headroom;
  logic             full;
  logic             font_chg;
  logic             dx_nz;
  logic             dy_nz;
  logic             esc_lit;
  logic [3:0]       n_bytes;

  assign start = s_tuser[0];
  assign font  = s_tdata[7:0];
  assign dx    = s_tdata[23:8];
  assign dy    = s_tdata[39:24];
  assign ch    = s_tdata[47:40];

  assign s_tready = push_ready;
  assign push     = s_tvalid && push_ready;

  always_comb begin
    cnt_eff       = start ? '0 : byte_count;
    valid_eff     = !start && prev_font_valid;
    with_headroom = {1'b0, cnt_eff} + (CNT_W + 1)'(tbee_pkg::HEADROOM);
    full          = with_headroom >= (CNT_W + 1)'(BATCH_CAPACITY);
    font_chg      = !valid_eff || (font != prev_font);
    dx_nz         = dx != 16'h0000;
    dy_nz         = dy != 16'h0000;
    esc_lit       = ch == tbee_pkg::ESC_CHAR;
    n_bytes       = (font_chg ? 4'd3 : 4'd0) + (dx_nz ? 4'd4 : 4'd0)
                  + (dy_nz ? 4'd4 : 4'd0) + (esc_lit ? 4'd2 : 4'd1);
    byte_count_next = full ? cnt_eff : cnt_eff + CNT_W'(n_bytes);

    push_cmd.full     = full;
    push_cmd.font_chg = font_chg;
    push_cmd.dx_nz    = dx_nz;
    push_cmd.dy_nz    = dy_nz;
    push_cmd.esc_lit  = esc_lit;
    push_cmd.font     = font;
    push_cmd.dx       = dx;
    push_cmd.dy       = dy;
    push_cmd.ch       = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      prev_font       <= '0;
      prev_font_valid <= 1'b0;
    end else if (push) begin
      byte_count <= byte_count_next;
      if (full) begin
        prev_font_valid <= valid_eff;
      end else begin
        prev_font       <= font;
        prev_font_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tbee_queue.sv
// Short command queue between the front and the back of the encoder.
// Depends on tbee_pkg for the command record and the depth.
`timescale 1ns / 1ps
`default_nettype none

module tbee_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tbee_pkg::cmd_t push_cmd,
  output logic                push_ready,
  input  wire logic           pop,
  output tbee_pkg::cmd_t      pop_cmd,
  output logic                pop_valid
);

  tbee_pkg::cmd_t                    entries [tbee_pkg::QDEPTH];
  logic [tbee_pkg::QPTR_W-1:0]       wr_ptr;
  logic [tbee_pkg::QPTR_W-1:0]       rd_ptr;
  logic [tbee_pkg::QPTR_W:0]         count;

  assign push_ready = count != (tbee_pkg::QPTR_W + 1)'(tbee_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tbee_back.sv
// Back end of the encoder: walks one command's pending byte slots to drive
// the output register one byte per cycle unless stalled. Uses tbee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbee_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tbee_pkg::cmd_t                  pop_cmd,
  input  wire logic                            pop_valid,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [tbee_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  output logic [0:0]                           m_tuser
);

  localparam int unsigned NSLOT = 13;

  localparam logic [3:0] SLOT_F_ESC = 4'd0;
  localparam logic [3:0] SLOT_F_TAG = 4'd1;
  localparam logic [3:0] SLOT_F_ID  = 4'd2;
  localparam logic [3:0] SLOT_X_ESC = 4'd3;
  localparam logic [3:0] SLOT_X_TAG = 4'd4;
  localparam logic [3:0] SLOT_X_HI  = 4'd5;
  localparam logic [3:0] SLOT_X_LO  = 4'd6;
  localparam logic [3:0] SLOT_Y_ESC = 4'd7;
  localparam logic [3:0] SLOT_Y_TAG = 4'd8;
  localparam logic [3:0] SLOT_Y_HI  = 4'd9;
  localparam logic [3:0] SLOT_Y_LO  = 4'd10;
  localparam logic [3:0] SLOT_C_ESC = 4'd11;
  localparam logic [3:0] SLOT_CHAR  = 4'd12;

  tbee_pkg::cmd_t   cur;
  logic [NSLOT-1:0] pending;
  logic [NSLOT-1:0] pending_rest;
  logic [NSLOT-1:0] load_mask;
  logic [3:0]       slot;
  logic [7:0]       slot_byte;
  logic             emit;
  logic             is_last;

  always_comb begin
    slot = SLOT_CHAR;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        slot = 4'(i);
      end
    end

    unique case (slot)
      SLOT_F_ESC, SLOT_X_ESC, SLOT_Y_ESC, SLOT_C_ESC: slot_byte = tbee_pkg::ESC_CHAR;
      SLOT_F_TAG: slot_byte = tbee_pkg::FONT_TAG;
      SLOT_F_ID:  slot_byte = cur.font;
      SLOT_X_TAG: slot_byte = tbee_pkg::XOFF_TAG;
      SLOT_X_HI:  slot_byte = cur.dx[15:8];
      SLOT_X_LO:  slot_byte = cur.dx[7:0];
      SLOT_Y_TAG: slot_byte = tbee_pkg::YOFF_TAG;
      SLOT_Y_HI:  slot_byte = cur.dy[15:8];
      SLOT_Y_LO:  slot_byte = cur.dy[7:0];
      SLOT_CHAR:  slot_byte = cur.full ? tbee_pkg::FULL_BYTE : cur.ch;
      default:    slot_byte = tbee_pkg::FULL_BYTE;
    endcase

    if (pop_cmd.full) begin
      load_mask = NSLOT'(1) << SLOT_CHAR;
    end else begin
      load_mask = {1'b1, pop_cmd.esc_lit, {4{pop_cmd.dy_nz}}, {4{pop_cmd.dx_nz}},
                   {3{pop_cmd.font_chg}}};
    end

    pending_rest = pending & (pending - 1'b1);
    is_last      = pending_rest == '0;
    emit         = (pending != '0) && (!m_tvalid || m_tready);
    pop          = pop_valid && ((pending == '0) || (emit && is_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        pending <= load_mask;
      end else if (emit) begin
        pending <= pending_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_cmd;
    end
    if (emit) begin
      m_tdata    <= slot_byte;
      m_tlast    <= is_last;
      m_tuser[0] <= cur.full;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/text_batch_escape_encoder_unit.sv
// Top level of the text batch escape encoder.
// Depends on tbee_pkg, tbee_front, tbee_queue and tbee_back.
//
// Channel  Dir  Group               Content
// s_*      in   tvalid/tready       tdata: font_id[7:0], dx[23:8], dy[39:24], char_code[47:40]
//                                   tuser: start_batch
// m_*      out  tvalid/tready       tdata: out_byte[7:0]; tlast: last_byte; tuser: batch_full
//
// One output byte per cycle while m_tready is high; a glyph takes 1 to 13 bytes,
// walked by the back end's byte sequencer into the byte-wide output register.
// The front takes a glyph every cycle while the four-entry command queue has room.
// Reset is synchronous and clears the batch count, the font and the queue.
// A stall on the output holds the current byte; the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_batch_escape_encoder_unit #(
  parameter int unsigned BATCH_CAPACITY = tbee_pkg::BATCH_CAPACITY_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // font_id[7:0], dx[23:8], dy[39:24], char_code[47:40]
  input  wire logic [tbee_pkg::IN_DATA_W-1:0]  s_tdata,
  // start_batch[0]
  input  wire logic [0:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // out_byte[7:0]
  output logic [tbee_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  // batch_full[0]
  output logic [0:0]                           m_tuser
);

  logic           push;
  logic           push_ready;
  tbee_pkg::cmd_t push_cmd;
  logic           pop;
  logic           pop_valid;
  tbee_pkg::cmd_t pop_cmd;

  tbee_front #(
    .BATCH_CAPACITY(BATCH_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready)
  );

  tbee_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid)
  );

  tbee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_cmd  (pop_cmd),
    .pop_valid(pop_valid),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: hdl/tbee_checker.sv
// Port-level checker for the text batch escape encoder, bound to the top.
// Depends on text_batch_escape_encoder_unit and tbee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbee_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [tbee_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic [0:0]                      s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [tbee_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            m_tlast,
  input wire logic [0:0]                      m_tuser
);

  // A rejected glyph is a single transfer.
  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("full result without tlast");

  a_full_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == tbee_pkg::FULL_BYTE)
    else $error("full result carries a nonzero byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transfer changed");

endmodule

bind text_batch_escape_encoder_unit tbee_checker u_tbee_checker (.*);

`default_nettype wire
